// File: hdl/trg_pkg.sv
// ============================================================================
// Touch report gate package
// Shared widths, register map, result kinds and configuration types.
// ============================================================================
`default_nettype none

package trg_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int TIME_BITS  = 32;
    localparam int RAW_BITS   = 16;
    localparam int PRESS_BITS = 8;
    localparam int TIP_BITS   = 4;
    localparam int ID_BITS    = 4;
    localparam int NOW_BITS   = 32;
    localparam int SPAN_BITS  = 16;
    localparam int IVL_BITS   = 16;
    localparam int PROD_BITS  = PIXEL_BITS + RAW_BITS;
    localparam int STEP_BITS  = $clog2(PIXEL_BITS + 1);

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [TIP_BITS-1:0] TIP_CONTACT = TIP_BITS'(1);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SCREEN_W = 3'd0,
        REG_SCREEN_H = 3'd1,
        REG_SPAN_X   = 3'd2,
        REG_SPAN_Y   = 3'd3,
        REG_INTERVAL = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_CONTACT  = 2'd0,
        KIND_LIFT     = 2'd1,
        KIND_PTR_DOWN = 2'd2,
        KIND_PTR_UP   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] screen_w;
        logic [PIXEL_BITS-1:0] screen_h;
        logic [SPAN_BITS-1:0]  span_x;
        logic [SPAN_BITS-1:0]  span_y;
        logic [IVL_BITS-1:0]   interval;
    } cfg_t;

    localparam logic [PIXEL_BITS-1:0] RESET_SCREEN_W = PIXEL_BITS'(800);
    localparam logic [PIXEL_BITS-1:0] RESET_SCREEN_H = PIXEL_BITS'(480);
    localparam logic [SPAN_BITS-1:0]  RESET_SPAN     = SPAN_BITS'(65535);
    localparam logic [IVL_BITS-1:0]   RESET_INTERVAL = IVL_BITS'(16);

endpackage

`default_nettype wire

// File: hdl/trg_ifs.sv
// ============================================================================
// Touch report gate channels
// Valid/ready channels for scan requests and result requests.
// ============================================================================
`default_nettype none

interface trg_scan_if
    import trg_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [RAW_BITS-1:0]   raw_x_first;
    logic [RAW_BITS-1:0]   raw_y_first;
    logic [PRESS_BITS-1:0] press_first;
    logic [TIP_BITS-1:0]   tip_first;
    logic [ID_BITS-1:0]    id_first;
    logic [RAW_BITS-1:0]   raw_x_second;
    logic [RAW_BITS-1:0]   raw_y_second;
    logic [PRESS_BITS-1:0] press_second;
    logic [TIP_BITS-1:0]   tip_second;
    logic [ID_BITS-1:0]    id_second;
    logic [NOW_BITS-1:0]   now_ms;

    modport source (
        output valid, raw_x_first, raw_y_first, press_first, tip_first, id_first,
               raw_x_second, raw_y_second, press_second, tip_second, id_second,
               now_ms,
        input  ready
    );
    modport sink (
        input  valid, raw_x_first, raw_y_first, press_first, tip_first, id_first,
               raw_x_second, raw_y_second, press_second, tip_second, id_second,
               now_ms,
        output ready
    );
endinterface

interface trg_result_if
    import trg_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [ID_BITS-1:0]    slot;
    logic [PIXEL_BITS-1:0] pos_x;
    logic [PIXEL_BITS-1:0] pos_y;
    logic [PRESS_BITS-1:0] pressure;
    logic                  last;

    modport source (
        output valid, kind, slot, pos_x, pos_y, pressure, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, pos_x, pos_y, pressure, last,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/touch_report_gate_core.sv
// ============================================================================
// Touch report gate core
// Gates two-touch scans, scales their coordinates and emits slot and pointer
// results.
// ============================================================================
// Reset restores the register defaults and clears the stored tips and report time.
// A scan that makes no report is taken while the core is idle and gives no result.
// A reported scan runs four scalings through one shared bit-serial divider, each
// passing through a check state, the iteration steps and a done state (a zero span or an
// overflowing quotient ends at the check), then one result per touching or lifting slot
// and one for the pointer; the next scan is taken once the pointer result is loaded.
`default_nettype none

module touch_report_gate_core
    import trg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    trg_scan_if.sink                      scan,
    trg_result_if.source                  result,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        E_FIRST   = 3'b001,
        E_SECOND  = 3'b010,
        E_POINTER = 3'b100
    } emit_step_t;

    cfg_t cfg;

    trg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t                state_reg, state_next;
    emit_step_t            step_reg, step_next;
    logic [1:0]            div_idx_reg, div_idx_next;

    logic [TIP_BITS-1:0]   prev_tip1_reg, prev_tip1_next;
    logic [TIP_BITS-1:0]   prev_tip2_reg, prev_tip2_next;
    logic [TIME_BITS-1:0]  last_time_reg, last_time_next;

    logic [RAW_BITS-1:0]   raw_reg [4];
    logic [PIXEL_BITS-1:0] pos_reg [4];
    logic [PRESS_BITS-1:0] press1_reg, press2_reg;
    logic [ID_BITS-1:0]    id1_reg, id2_reg;
    logic                  contact1_reg, lift1_reg, contact2_reg, lift2_reg, ptr_reg;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [ID_BITS-1:0]    out_slot_reg, out_slot_next;
    logic [PIXEL_BITS-1:0] out_x_reg, out_x_next;
    logic [PIXEL_BITS-1:0] out_y_reg, out_y_next;
    logic [PRESS_BITS-1:0] out_p_reg, out_p_next;
    logic                  out_last_reg, out_last_next;

    logic                  scan_take;
    logic                  report;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  out_free;
    logic                  div_start;
    logic                  div_done;
    logic [PIXEL_BITS-1:0] div_value;
    logic [RAW_BITS-1:0]   div_raw;
    logic [PIXEL_BITS-1:0] div_screen;
    logic [SPAN_BITS-1:0]  div_span;

    assign scan.ready = (state_reg == S_IDLE);
    assign scan_take  = scan.valid && scan.ready;
    assign elapsed    = scan.now_ms[TIME_BITS-1:0] - last_time_reg;
    assign report     = (scan.tip_first != prev_tip1_reg)
                     || (scan.tip_second != prev_tip2_reg)
                     || (elapsed > TIME_BITS'(cfg.interval));
    assign out_free   = !out_valid_reg || result.ready;

    // Division order: first x, first y, second x, second y.
    assign div_start  = (state_reg == S_START);
    assign div_raw    = raw_reg[div_idx_reg];
    assign div_screen = div_idx_reg[0] ? cfg.screen_h : cfg.screen_w;
    assign div_span   = div_idx_reg[0] ? cfg.span_y : cfg.span_x;

    trg_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .raw    (div_raw),
        .screen (div_screen),
        .span   (div_span),
        .done   (div_done),
        .value  (div_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        div_idx_next   = div_idx_reg;
        prev_tip1_next = prev_tip1_reg;
        prev_tip2_next = prev_tip2_reg;
        last_time_next = last_time_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_p_next     = out_p_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (scan_take && report)
                begin
                    prev_tip1_next = scan.tip_first;
                    prev_tip2_next = scan.tip_second;
                    last_time_next = scan.now_ms[TIME_BITS-1:0];
                    div_idx_next   = 2'd0;
                    state_next     = S_START;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    div_idx_next = div_idx_reg + 2'd1;
                    if (div_idx_reg == 2'd3)
                    begin
                        step_next  = E_FIRST;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_EMIT:
            begin
                unique case (step_reg)
                    E_FIRST:
                    begin
                        if (!(contact1_reg || lift1_reg))
                        begin
                            step_next = E_SECOND;
                        end
                        else if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = contact1_reg ? KIND_CONTACT : KIND_LIFT;
                            out_slot_next  = id1_reg;
                            out_x_next     = contact1_reg ? pos_reg[0] : '0;
                            out_y_next     = contact1_reg ? pos_reg[1] : '0;
                            out_p_next     = contact1_reg ? press1_reg : '0;
                            out_last_next  = 1'b0;
                            step_next      = E_SECOND;
                        end
                    end
                    E_SECOND:
                    begin
                        if (!(contact2_reg || lift2_reg))
                        begin
                            step_next = E_POINTER;
                        end
                        else if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = contact2_reg ? KIND_CONTACT : KIND_LIFT;
                            out_slot_next  = id2_reg;
                            out_x_next     = contact2_reg ? pos_reg[2] : '0;
                            out_y_next     = contact2_reg ? pos_reg[3] : '0;
                            out_p_next     = contact2_reg ? press2_reg : '0;
                            out_last_next  = 1'b0;
                            step_next      = E_POINTER;
                        end
                    end
                    E_POINTER:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ptr_reg ? KIND_PTR_DOWN : KIND_PTR_UP;
                            out_slot_next  = '0;
                            out_x_next     = ptr_reg ? pos_reg[0] : '0;
                            out_y_next     = ptr_reg ? pos_reg[1] : '0;
                            out_p_next     = ptr_reg ? press1_reg : '0;
                            out_last_next  = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        step_next = E_POINTER;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= E_FIRST;
            div_idx_reg   <= 2'd0;
            prev_tip1_reg <= '0;
            prev_tip2_reg <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            div_idx_reg   <= div_idx_next;
            prev_tip1_reg <= prev_tip1_next;
            prev_tip2_reg <= prev_tip2_next;
            last_time_reg <= last_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_slot_reg <= out_slot_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_p_reg    <= out_p_next;
        out_last_reg <= out_last_next;
        if (scan_take && report)
        begin
            raw_reg[0]   <= scan.raw_x_first;
            raw_reg[1]   <= scan.raw_y_first;
            raw_reg[2]   <= scan.raw_x_second;
            raw_reg[3]   <= scan.raw_y_second;
            press1_reg   <= scan.press_first;
            press2_reg   <= scan.press_second;
            id1_reg      <= scan.id_first;
            id2_reg      <= scan.id_second;
            contact1_reg <= (scan.tip_first == TIP_CONTACT);
            lift1_reg    <= (scan.tip_first != TIP_CONTACT) && (prev_tip1_reg == TIP_CONTACT);
            contact2_reg <= (scan.tip_second == TIP_CONTACT);
            lift2_reg    <= (scan.tip_second != TIP_CONTACT)
                         && (prev_tip2_reg == TIP_CONTACT);
            ptr_reg      <= (scan.tip_first != '0);
        end
        if ((state_reg == S_WAIT) && div_done)
        begin
            pos_reg[div_idx_reg] <= div_value;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.kind     = out_kind_reg;
    assign result.slot     = out_slot_reg;
    assign result.pos_x    = out_x_reg;
    assign result.pos_y    = out_y_reg;
    assign result.pressure = out_p_reg;
    assign result.last     = out_last_reg;

    a_last_is_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == ((out_kind_reg == KIND_PTR_DOWN)
                                         || (out_kind_reg == KIND_PTR_UP))))
        else $error("last flag does not match a pointer result");

    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_kind_reg == KIND_LIFT) || (out_kind_reg == KIND_PTR_UP)))
        |-> ((out_x_reg == '0) && (out_y_reg == '0) && (out_p_reg == '0)))
        else $error("lift or release result carries a position or pressure");

    a_scan_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        scan_take |=> ((state_reg == S_IDLE) || (state_reg == S_START)))
        else $error("accepted scan led to an unexpected state");

endmodule

`default_nettype wire

// File: hdl/trg_regs.sv
// ============================================================================
// Touch report gate configuration registers
// APB-style register file holding screen size, sensor spans and interval.
// ============================================================================
`default_nettype none

module trg_regs
    import trg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SCREEN_W: cfg_next.screen_w = pwdata[PIXEL_BITS-1:0];
                REG_SCREEN_H: cfg_next.screen_h = pwdata[PIXEL_BITS-1:0];
                REG_SPAN_X:   cfg_next.span_x   = pwdata[SPAN_BITS-1:0];
                REG_SPAN_Y:   cfg_next.span_y   = pwdata[SPAN_BITS-1:0];
                REG_INTERVAL: cfg_next.interval = pwdata[IVL_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SCREEN_W: prdata = APB_DATA_BITS'(cfg_reg.screen_w);
            REG_SCREEN_H: prdata = APB_DATA_BITS'(cfg_reg.screen_h);
            REG_SPAN_X:   prdata = APB_DATA_BITS'(cfg_reg.span_x);
            REG_SPAN_Y:   prdata = APB_DATA_BITS'(cfg_reg.span_y);
            REG_INTERVAL: prdata = APB_DATA_BITS'(cfg_reg.interval);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_w <= RESET_SCREEN_W;
            cfg_reg.screen_h <= RESET_SCREEN_H;
            cfg_reg.span_x   <= RESET_SPAN;
            cfg_reg.span_y   <= RESET_SPAN;
            cfg_reg.interval <= RESET_INTERVAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/trg_scale.sv
// ============================================================================
// Touch report gate coordinate scaler
// Computes min(screen*raw/span, screen-1) with a bit-serial restoring divider.
// ============================================================================
`default_nettype none

module trg_scale
    import trg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [RAW_BITS-1:0]   raw,
    input  wire logic [PIXEL_BITS-1:0] screen,
    input  wire logic [SPAN_BITS-1:0]  span,
    output logic                       done,
    output logic      [PIXEL_BITS-1:0] value
);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_CHECK = 4'b0010,
        D_ITER  = 4'b0100,
        D_DONE  = 4'b1000
    } div_state_t;

    div_state_t            state_reg, state_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [SPAN_BITS-1:0]  span_reg, span_next;
    logic [PIXEL_BITS-1:0] limit_reg, limit_next;
    logic [SPAN_BITS-1:0]  rem_reg, rem_next;
    logic [PIXEL_BITS-1:0] quo_reg, quo_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  done_reg, done_next;
    logic [PIXEL_BITS-1:0] value_reg, value_next;

    logic [SPAN_BITS:0]    trial;
    logic                  fits;
    logic [SPAN_BITS:0]    diff;
    logic [SPAN_BITS-1:0]  prod_high;

    assign trial     = {rem_reg, quo_reg[PIXEL_BITS-1]};
    assign fits      = trial >= {1'b0, span_reg};
    assign diff      = trial - {1'b0, span_reg};
    assign prod_high = prod_reg[PROD_BITS-1:PIXEL_BITS];

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        span_next  = span_reg;
        limit_next = limit_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    prod_next  = PROD_BITS'(screen) * PROD_BITS'(raw);
                    span_next  = span;
                    limit_next = (screen == '0) ? '0 : screen - PIXEL_BITS'(1);
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // A quotient that needs more than PIXEL_BITS bits is above any limit.
                if ((span_reg == '0) || (prod_high >= span_reg))
                begin
                    value_next = limit_reg;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = prod_high;
                    quo_next   = prod_reg[PIXEL_BITS-1:0];
                    step_next  = STEP_BITS'(PIXEL_BITS);
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                rem_next  = fits ? diff[SPAN_BITS-1:0] : trial[SPAN_BITS-1:0];
                quo_next  = {quo_reg[PIXEL_BITS-2:0], fits};
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == STEP_BITS'(1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                value_next = (quo_reg > limit_reg) ? limit_reg : quo_reg;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        span_reg  <= span_next;
        limit_reg <= limit_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
        value_reg <= value_next;
    end

    assign done  = done_reg;
    assign value = value_reg;

    // The partial remainder must always stay below the divisor.
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_ITER) |-> (rem_reg < span_reg))
        else $error("divider remainder reached the divisor");

    a_value_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (value_reg <= limit_reg))
        else $error("scaled value above clamp limit");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Touch report gate testbench
// Drives two-touch scan requests through the gate under several register
// settings and checks each slot and pointer result against a predictor of
// the gate's scaling, tip tracking and report interval.
// ============================================================================

module tb;
    import trg_pkg::*;

    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [RAW_BITS-1:0]   raw_x_first;
        logic [RAW_BITS-1:0]   raw_y_first;
        logic [PRESS_BITS-1:0] press_first;
        logic [TIP_BITS-1:0]   tip_first;
        logic [ID_BITS-1:0]    id_first;
        logic [RAW_BITS-1:0]   raw_x_second;
        logic [RAW_BITS-1:0]   raw_y_second;
        logic [PRESS_BITS-1:0] press_second;
        logic [TIP_BITS-1:0]   tip_second;
        logic [ID_BITS-1:0]    id_second;
        logic [NOW_BITS-1:0]   now_ms;
    } scan_req_t;

    typedef struct {
        kind_t                 kind;
        logic [ID_BITS-1:0]    slot;
        logic [PIXEL_BITS-1:0] pos_x;
        logic [PIXEL_BITS-1:0] pos_y;
        logic [PRESS_BITS-1:0] pressure;
        logic                  last;
    } touch_result_t;

    class gate_scoreboard;
        cfg_t                  cfg;
        logic [TIP_BITS-1:0]   tip_first_seen;
        logic [TIP_BITS-1:0]   tip_second_seen;
        logic [TIME_BITS-1:0]  report_ms;
        touch_result_t         due_results[$];
        int                    errors;

        function new();
            cfg.screen_w    = RESET_SCREEN_W;
            cfg.screen_h    = RESET_SCREEN_H;
            cfg.span_x      = RESET_SPAN;
            cfg.span_y      = RESET_SPAN;
            cfg.interval    = RESET_INTERVAL;
            tip_first_seen  = '0;
            tip_second_seen = '0;
            report_ms       = '0;
            errors          = 0;
        endfunction

        function logic [PIXEL_BITS-1:0] to_pixels(logic [RAW_BITS-1:0] raw,
                                                  logic [PIXEL_BITS-1:0] screen,
                                                  logic [SPAN_BITS-1:0] span);
            logic [PIXEL_BITS-1:0] limit;
            logic [PROD_BITS-1:0]  quotient;
            limit = (screen == '0) ? '0 : screen - 1'b1;
            if (span == '0)
            begin
                return limit;
            end
            quotient = (screen * raw) / span;
            return (quotient > limit) ? limit : quotient[PIXEL_BITS-1:0];
        endfunction

        function void add(kind_t kind, logic [ID_BITS-1:0] slot,
                          logic [PIXEL_BITS-1:0] x, logic [PIXEL_BITS-1:0] y,
                          logic [PRESS_BITS-1:0] pressure, logic last);
            touch_result_t r;
            r.kind     = kind;
            r.slot     = slot;
            r.pos_x    = x;
            r.pos_y    = y;
            r.pressure = pressure;
            r.last     = last;
            due_results.push_back(r);
        endfunction

        function void note_scan(scan_req_t s);
            logic [PIXEL_BITS-1:0] x1;
            logic [PIXEL_BITS-1:0] y1;
            logic [PIXEL_BITS-1:0] x2;
            logic [PIXEL_BITS-1:0] y2;
            logic [TIME_BITS-1:0]  elapsed;
            x1 = to_pixels(s.raw_x_first, cfg.screen_w, cfg.span_x);
            y1 = to_pixels(s.raw_y_first, cfg.screen_h, cfg.span_y);
            x2 = to_pixels(s.raw_x_second, cfg.screen_w, cfg.span_x);
            y2 = to_pixels(s.raw_y_second, cfg.screen_h, cfg.span_y);
            elapsed = TIME_BITS'(s.now_ms) - report_ms;
            if (s.tip_first == tip_first_seen && s.tip_second == tip_second_seen &&
                elapsed <= cfg.interval)
            begin
                return;
            end
            if (s.tip_first == TIP_CONTACT)
            begin
                add(KIND_CONTACT, s.id_first, x1, y1, s.press_first, 1'b0);
            end
            else if (tip_first_seen == TIP_CONTACT)
            begin
                add(KIND_LIFT, s.id_first, '0, '0, '0, 1'b0);
            end
            if (s.tip_second == TIP_CONTACT)
            begin
                add(KIND_CONTACT, s.id_second, x2, y2, s.press_second, 1'b0);
            end
            else if (tip_second_seen == TIP_CONTACT)
            begin
                add(KIND_LIFT, s.id_second, '0, '0, '0, 1'b0);
            end
            if (s.tip_first != '0)
            begin
                add(KIND_PTR_DOWN, '0, x1, y1, s.press_first, 1'b1);
            end
            else
            begin
                add(KIND_PTR_UP, '0, '0, '0, '0, 1'b1);
            end
            tip_first_seen  = s.tip_first;
            tip_second_seen = s.tip_second;
            report_ms       = TIME_BITS'(s.now_ms);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(touch_result_t got);
            touch_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result request arrived with no result pending");
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("slot", want.slot, got.slot);
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("pressure", want.pressure, got.pressure);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    trg_scan_if   scan_ch();
    trg_result_if result_ch();

    gate_scoreboard sb;

    logic [NOW_BITS-1:0] gen_now;
    logic [TIP_BITS-1:0] gen_tip_first;
    logic [TIP_BITS-1:0] gen_tip_second;

    int unsigned ready_cycles = 0;
    int unsigned ready_mode = 0;
    int unsigned stall_left = 0;

    touch_result_t seen_result;
    scan_req_t     seen_scan;

    touch_report_gate_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            ready_cycles++;
            if (ready_cycles % 300 == 0)
            begin
                ready_mode = $urandom_range(0, 3);
            end
            case (ready_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= 1'($urandom_range(0, 1));
                2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        result_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        result_ch.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = $urandom_range(5, 30);
                        end
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen_result.kind     = kind_t'(result_ch.kind);
                seen_result.slot     = result_ch.slot;
                seen_result.pos_x    = result_ch.pos_x;
                seen_result.pos_y    = result_ch.pos_y;
                seen_result.pressure = result_ch.pressure;
                seen_result.last     = result_ch.last;
                sb.check_result(seen_result);
            end
            if (scan_ch.valid && scan_ch.ready)
            begin
                seen_scan.raw_x_first  = scan_ch.raw_x_first;
                seen_scan.raw_y_first  = scan_ch.raw_y_first;
                seen_scan.press_first  = scan_ch.press_first;
                seen_scan.tip_first    = scan_ch.tip_first;
                seen_scan.id_first     = scan_ch.id_first;
                seen_scan.raw_x_second = scan_ch.raw_x_second;
                seen_scan.raw_y_second = scan_ch.raw_y_second;
                seen_scan.press_second = scan_ch.press_second;
                seen_scan.tip_second   = scan_ch.tip_second;
                seen_scan.id_second    = scan_ch.id_second;
                seen_scan.now_ms       = scan_ch.now_ms;
                sb.note_scan(seen_scan);
            end
        end
    end

    function scan_req_t make_scan(logic [15:0] rx1, logic [15:0] ry1, logic [7:0] p1,
                                  logic [3:0] t1, logic [3:0] id1,
                                  logic [15:0] rx2, logic [15:0] ry2, logic [7:0] p2,
                                  logic [3:0] t2, logic [3:0] id2, logic [31:0] now);
        scan_req_t s;
        s.raw_x_first  = rx1;
        s.raw_y_first  = ry1;
        s.press_first  = p1;
        s.tip_first    = t1;
        s.id_first     = id1;
        s.raw_x_second = rx2;
        s.raw_y_second = ry2;
        s.press_second = p2;
        s.tip_second   = t2;
        s.id_second    = id2;
        s.now_ms       = now;
        return s;
    endfunction

    function logic [RAW_BITS-1:0] rand_raw(logic [SPAN_BITS-1:0] span);
        case ($urandom_range(0, 9))
            7: return '0;
            8: return '1;
            9: return span + RAW_BITS'($urandom_range(0, 2)) - 1'b1;
            default: return RAW_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function scan_req_t gen_scan();
        scan_req_t   s;
        int unsigned roll;
        logic [31:0] advance;
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            if (gen_tip_first > 1 || $urandom_range(0, 3) == 0)
            begin
                gen_tip_first = (gen_tip_first == TIP_CONTACT) ? '0 : TIP_CONTACT;
            end
            if (gen_tip_second > 1 || $urandom_range(0, 3) == 0)
            begin
                gen_tip_second = (gen_tip_second == TIP_CONTACT) ? '0 : TIP_CONTACT;
            end
        end
        else
        begin
            gen_tip_first  = TIP_BITS'($urandom_range(0, 15));
            gen_tip_second = TIP_BITS'($urandom_range(0, 15));
        end
        roll = $urandom_range(0, 9);
        if (roll < 4)
        begin
            advance = $urandom_range(0, sb.cfg.interval);
        end
        else if (roll < 8)
        begin
            advance = sb.cfg.interval + $urandom_range(1, 40);
        end
        else if (roll == 8)
        begin
            advance = '0;
        end
        else
        begin
            advance = $urandom;
        end
        gen_now = gen_now + advance;
        s.raw_x_first  = rand_raw(sb.cfg.span_x);
        s.raw_y_first  = rand_raw(sb.cfg.span_y);
        s.press_first  = PRESS_BITS'($urandom_range(0, 255));
        s.tip_first    = gen_tip_first;
        s.id_first     = ID_BITS'($urandom_range(0, 15));
        s.raw_x_second = rand_raw(sb.cfg.span_x);
        s.raw_y_second = rand_raw(sb.cfg.span_y);
        s.press_second = PRESS_BITS'($urandom_range(0, 255));
        s.tip_second   = gen_tip_second;
        s.id_second    = ($urandom_range(0, 9) == 0) ? s.id_first
                                                     : ID_BITS'($urandom_range(0, 15));
        s.now_ms       = gen_now;
        return s;
    endfunction

    task send_scan(input scan_req_t s);
        scan_ch.valid        <= 1'b1;
        scan_ch.raw_x_first  <= s.raw_x_first;
        scan_ch.raw_y_first  <= s.raw_y_first;
        scan_ch.press_first  <= s.press_first;
        scan_ch.tip_first    <= s.tip_first;
        scan_ch.id_first     <= s.id_first;
        scan_ch.raw_x_second <= s.raw_x_second;
        scan_ch.raw_y_second <= s.raw_y_second;
        scan_ch.press_second <= s.press_second;
        scan_ch.tip_second   <= s.tip_second;
        scan_ch.id_second    <= s.id_second;
        scan_ch.now_ms       <= s.now_ms;
        @(posedge clk);
        while (!scan_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task run_scans(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_scan(gen_scan());
                    sent++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0 || sent >= count)
            begin
                scan_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task wait_for_drain();
        @(posedge clk);
        while (sb.due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCREEN_W: sb.cfg.screen_w = value[PIXEL_BITS-1:0];
            REG_SCREEN_H: sb.cfg.screen_h = value[PIXEL_BITS-1:0];
            REG_SPAN_X:   sb.cfg.span_x   = value[SPAN_BITS-1:0];
            REG_SPAN_Y:   sb.cfg.span_y   = value[SPAN_BITS-1:0];
            REG_INTERVAL: sb.cfg.interval = value[IVL_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task apply_config(input logic [PIXEL_BITS-1:0] width, input logic [PIXEL_BITS-1:0] height,
                      input logic [SPAN_BITS-1:0] span_x, input logic [SPAN_BITS-1:0] span_y,
                      input logic [IVL_BITS-1:0] interval);
        write_reg(REG_SCREEN_W, APB_DATA_BITS'(width));
        write_reg(REG_SCREEN_H, APB_DATA_BITS'(height));
        write_reg(REG_SPAN_X, APB_DATA_BITS'(span_x));
        write_reg(REG_SPAN_Y, APB_DATA_BITS'(span_y));
        write_reg(REG_INTERVAL, APB_DATA_BITS'(interval));
    endtask

    task run_directed();
        send_scan(make_scan(100, 200, 10, 0, 0, 300, 400, 20, 0, 0, 5));
        send_scan(make_scan(65535, 65535, 255, 1, 15, 0, 0, 0, 0, 0, 6));
        send_scan(make_scan(0, 0, 0, 1, 0, 65535, 65535, 255, 1, 15, 7));
        send_scan(make_scan(1000, 2000, 30, 1, 3, 4000, 5000, 40, 1, 4, 23));
        send_scan(make_scan(1000, 2000, 30, 1, 3, 4000, 5000, 40, 1, 4, 24));
        send_scan(make_scan(500, 600, 70, 0, 3, 700, 800, 90, 0, 4, 25));
        send_scan(make_scan(32767, 32768, 100, 2, 6, 0, 0, 0, 0, 6, 26));
        send_scan(make_scan(40000, 20000, 1, 15, 9, 20000, 40000, 2, 15, 9, 27));
        send_scan(make_scan(11111, 22222, 33, 1, 7, 44444, 55555, 66, 1, 7, 28));
        send_scan(make_scan(65535, 0, 255, 1, 7, 0, 65535, 0, 1, 7, 32'hFFFF_FFF0));
        send_scan(make_scan(1, 2, 3, 1, 7, 4, 5, 6, 1, 7, 32'h0000_0000));
        send_scan(make_scan(1, 2, 3, 1, 7, 4, 5, 6, 1, 7, 32'h0000_0001));
        send_scan(make_scan(9000, 9000, 9, 0, 1, 60000, 30000, 200, 1, 2, 2));
        send_scan(make_scan(9000, 9000, 9, 0, 1, 60000, 30000, 200, 0, 2, 3));
        send_scan(make_scan(21845, 43690, 85, 8, 10, 43690, 21845, 170, 4, 5, 4));
        send_scan(make_scan(21845, 43690, 85, 8, 10, 43690, 21845, 170, 4, 5, 32'hFFFF_FFFF));
        send_scan(make_scan(32768, 16384, 128, 1, 5, 12345, 54321, 1, 1, 10, 32'hFFFF_FFFF));
        scan_ch.valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        scan_ch.valid        <= 1'b0;
        scan_ch.raw_x_first  <= '0;
        scan_ch.raw_y_first  <= '0;
        scan_ch.press_first  <= '0;
        scan_ch.tip_first    <= '0;
        scan_ch.id_first     <= '0;
        scan_ch.raw_x_second <= '0;
        scan_ch.raw_y_second <= '0;
        scan_ch.press_second <= '0;
        scan_ch.tip_second   <= '0;
        scan_ch.id_second    <= '0;
        scan_ch.now_ms       <= '0;
        gen_now        = 32'h0000_1000;
        gen_tip_first  = '0;
        gen_tip_second = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_drain();

        apply_config(12'd4095, 12'd4095, 16'd1, 16'd1, 16'd0);
        run_scans(42);
        wait_for_drain();

        apply_config(12'd1, 12'd1, 16'd65535, 16'd65535, 16'd65535);
        run_scans(42);
        wait_for_drain();

        apply_config(12'd0, 12'd4095, 16'd0, 16'd65535, 16'd1);
        run_scans(42);
        wait_for_drain();

        apply_config(12'd4095, 12'd0, 16'd40000, 16'd0, 16'd300);
        run_scans(42);
        wait_for_drain();

        repeat (2)
        begin
            apply_config(PIXEL_BITS'($urandom_range(1, 4095)),
                         PIXEL_BITS'($urandom_range(1, 4095)),
                         SPAN_BITS'($urandom_range(1, 65535)),
                         SPAN_BITS'($urandom_range(1, 65535)),
                         IVL_BITS'($urandom_range(0, 64)));
            run_scans(42);
            wait_for_drain();
        end

        if (sb.errors == 0 && sb.due_results.size() == 0)
        begin
            $display("touch_report_gate_core test passed");
        end
        else
        begin
            $display("touch_report_gate_core test failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("touch_report_gate_core test failed");
        $finish;
    end

endmodule
